[design/wsdf_pkg.sv]
// shared types and constants for the websocket frame deframer and unmasker
// no dependencies; imported by every module of the block
package wsdf_pkg;

  // default receive buffer size in bytes
  localparam int RECV_BUFFER_BYTES_DEF = 4096;

  // header constants
  localparam int          CLOSE_OPCODE_BIT = 3;
  localparam int          MASK_FLAG_BIT    = 7;
  localparam logic [6:0]  LEN_CODE_MAX7    = 7'd125;
  localparam logic [6:0]  LEN_CODE_EXT16   = 7'd126;
  localparam logic [3:0]  EXT16_BYTES      = 4'd2;
  localparam logic [3:0]  EXT64_BYTES      = 4'd8;
  localparam logic [3:0]  MASK_KEY_BYTES   = 4'd4;
  localparam int          HDR_LEN_SHORT    = 2;
  localparam int          HDR_LEN_EXT16    = 4;
  localparam int          HDR_LEN_EXT64    = 10;

  // parse phase codes
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DROP    = 3'd5;

  // result status codes
  localparam logic [2:0] ST_PAYLOAD   = 3'd0;
  localparam logic [2:0] ST_NOPAYLOAD = 3'd1;
  localparam logic [2:0] ST_CLOSE     = 3'd2;
  localparam logic [2:0] ST_TOOLONG   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam int COUNT_W = 13;

  // one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } item_t;

  // one result
  typedef struct packed {
    logic [7:0]         payload_byte;
    logic [2:0]         status;
    logic               result_last;
    logic [COUNT_W-1:0] payload_count;
  } res_t;

endpackage

[design/wsdf_in_reg.sv]
// input register of the deframer: holds one received byte until parsed
// depends on wsdf_pkg
module wsdf_in_reg
  import wsdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       chunk_last,
  input  logic       advance,
  output logic       item_valid,
  output item_t      item
);

  // free when empty or when the held byte moves on this cycle
  assign in_ready = !item_valid || advance;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.rx_byte    <= rx_byte;
      item.chunk_last <= chunk_last;
    end
  end

endmodule

[design/wsdf_parser.sv]
// frame header parser, length check and payload unmasking, one byte per cycle while advance is high
// depends on wsdf_pkg
module wsdf_parser
  import wsdf_pkg::*;
#(
  parameter int RECV_BUFFER_BYTES = RECV_BUFFER_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  item_t item,
  output logic  res_valid,
  output res_t  res
);

  localparam int CBW   = $clog2(RECV_BUFFER_BYTES + 1);
  localparam int LEN_W = ($clog2(RECV_BUFFER_BYTES) + 1 > 7) ?
                         $clog2(RECV_BUFFER_BYTES) + 1 : 7;
  localparam logic [CBW-1:0]   BUF_LIMIT  = CBW'(RECV_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] ROOM_SHORT = LEN_W'(RECV_BUFFER_BYTES - HDR_LEN_SHORT);
  localparam logic [LEN_W-1:0] ROOM_EXT16 = LEN_W'(RECV_BUFFER_BYTES - HDR_LEN_EXT16);
  localparam logic [LEN_W-1:0] ROOM_EXT64 = LEN_W'(RECV_BUFFER_BYTES - HDR_LEN_EXT64);

  logic [2:0]         phase, phase_next;
  logic [3:0]         hbi, hbi_next;
  logic [6:0]         len_code, len_code_next;
  logic [LEN_W-1:0]   len, len_next;
  logic               len_big, len_big_next;
  logic               masked, masked_next;
  logic [31:0]        mask_key, mask_key_next;
  logic [COUNT_W-1:0] pcnt, pcnt_next;
  logic [CBW-1:0]     cbc, cbc_next;

  logic [3:0]         hbi_inc;
  logic [LEN_W+7:0]   ext_wide;
  logic               lk;
  logic [6:0]         lk_code;
  logic [LEN_W-1:0]   lk_len;
  logic               lk_big;
  logic               lk_mask;
  logic [LEN_W-1:0]   room;
  logic [7:0]         key_byte;
  logic               do_start;

  // next state and result for the byte at the input register
  always_comb begin
    phase_next    = phase;
    hbi_next      = hbi;
    len_code_next = len_code;
    len_next      = len;
    len_big_next  = len_big;
    masked_next   = masked;
    mask_key_next = mask_key;
    pcnt_next     = pcnt;
    cbc_next      = cbc;
    res_valid     = 1'b0;
    res           = '0;
    do_start      = 1'b0;
    lk            = 1'b0;
    lk_code       = len_code;
    lk_len        = len;
    lk_big        = len_big;
    lk_mask       = masked;
    room          = ROOM_SHORT;
    key_byte      = 8'd0;
    hbi_inc       = 4'(hbi + 4'd1);
    ext_wide      = {len, item.rx_byte};

    if (cbc >= BUF_LIMIT) begin
      // bytes past the buffer are ignored, only the chunk end matters
      if (item.chunk_last) begin
        do_start = 1'b1;
        if (phase == PH_PAYLOAD) begin
          res_valid         = 1'b1;
          res.status        = ST_NOPAYLOAD;
          res.result_last   = 1'b1;
          res.payload_count = pcnt;
        end else if (phase < PH_DROP) begin
          res_valid       = 1'b1;
          res.status      = ST_TRUNC;
          res.result_last = 1'b1;
        end
      end
    end else begin
      cbc_next = CBW'(cbc + 1'b1);
      unique case (phase)
        PH_HDR0: begin
          if (item.rx_byte[CLOSE_OPCODE_BIT]) begin
            res_valid       = 1'b1;
            res.status      = ST_CLOSE;
            res.result_last = 1'b1;
            if (item.chunk_last) begin
              do_start = 1'b1;
            end else begin
              phase_next = PH_DROP;
            end
          end else begin
            phase_next = PH_HDR1;
            if (item.chunk_last) begin
              res_valid       = 1'b1;
              res.status      = ST_TRUNC;
              res.result_last = 1'b1;
              do_start        = 1'b1;
            end
          end
        end
        PH_HDR1: begin
          masked_next   = item.rx_byte[MASK_FLAG_BIT];
          len_code_next = item.rx_byte[6:0];
          if (item.rx_byte[6:0] <= LEN_CODE_MAX7) begin
            len_next     = LEN_W'(item.rx_byte[6:0]);
            len_big_next = 1'b0;
            lk           = 1'b1;
            lk_code      = item.rx_byte[6:0];
            lk_len       = LEN_W'(item.rx_byte[6:0]);
            lk_big       = 1'b0;
            lk_mask      = item.rx_byte[MASK_FLAG_BIT];
          end else begin
            len_next     = '0;
            len_big_next = 1'b0;
            hbi_next     = 4'd0;
            phase_next   = PH_EXT;
            if (item.chunk_last) begin
              res_valid       = 1'b1;
              res.status      = ST_TRUNC;
              res.result_last = 1'b1;
              do_start        = 1'b1;
            end
          end
        end
        PH_EXT: begin
          // big-endian shift; bits beyond the kept width only mark too large
          len_next     = ext_wide[LEN_W-1:0];
          len_big_next = len_big | (|ext_wide[LEN_W+7:LEN_W]);
          hbi_next     = hbi_inc;
          if ((len_code == LEN_CODE_EXT16) ? (hbi_inc >= EXT16_BYTES)
                                           : (hbi_inc >= EXT64_BYTES)) begin
            lk     = 1'b1;
            lk_len = ext_wide[LEN_W-1:0];
            lk_big = len_big | (|ext_wide[LEN_W+7:LEN_W]);
          end else if (item.chunk_last) begin
            res_valid       = 1'b1;
            res.status      = ST_TRUNC;
            res.result_last = 1'b1;
            do_start        = 1'b1;
          end
        end
        PH_MASK: begin
          mask_key_next[{hbi[1:0], 3'b000} +: 8] = item.rx_byte;
          hbi_next = hbi_inc;
          if (hbi_inc >= MASK_KEY_BYTES) begin
            hbi_next   = 4'd0;
            phase_next = PH_PAYLOAD;
            if (item.chunk_last) begin
              res_valid       = 1'b1;
              res.status      = ST_NOPAYLOAD;
              res.result_last = 1'b1;
              do_start        = 1'b1;
            end
          end else if (item.chunk_last) begin
            res_valid       = 1'b1;
            res.status      = ST_TRUNC;
            res.result_last = 1'b1;
            do_start        = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          // key byte rotates with the payload index mod 4
          key_byte         = masked ? mask_key[{pcnt[1:0], 3'b000} +: 8] : 8'd0;
          pcnt_next        = COUNT_W'(pcnt + 1'b1);
          res_valid        = 1'b1;
          res.payload_byte = item.rx_byte ^ key_byte;
          res.status       = ST_PAYLOAD;
          if (item.chunk_last) begin
            res.result_last   = 1'b1;
            res.payload_count = COUNT_W'(pcnt + 1'b1);
            do_start          = 1'b1;
          end
        end
        default: begin
          // dropping the rest of the chunk
          if (item.chunk_last) begin
            do_start = 1'b1;
          end
        end
      endcase

      // length now known: check against room left after the header
      if (lk) begin
        if (lk_code <= LEN_CODE_MAX7) begin
          room = ROOM_SHORT;
        end else if (lk_code == LEN_CODE_EXT16) begin
          room = ROOM_EXT16;
        end else begin
          room = ROOM_EXT64;
        end
        if (lk_big || (lk_len > room)) begin
          res_valid       = 1'b1;
          res.status      = ST_TOOLONG;
          res.result_last = 1'b1;
          if (item.chunk_last) begin
            do_start = 1'b1;
          end else begin
            phase_next = PH_DROP;
          end
        end else begin
          hbi_next   = 4'd0;
          phase_next = lk_mask ? PH_MASK : PH_PAYLOAD;
          if (item.chunk_last) begin
            res_valid       = 1'b1;
            res.status      = lk_mask ? ST_TRUNC : ST_NOPAYLOAD;
            res.result_last = 1'b1;
            do_start        = 1'b1;
          end
        end
      end
    end

    // end of chunk: back to the first header byte
    if (do_start) begin
      phase_next    = PH_HDR0;
      hbi_next      = 4'd0;
      len_code_next = 7'd0;
      len_next      = '0;
      len_big_next  = 1'b0;
      masked_next   = 1'b0;
      mask_key_next = 32'd0;
      pcnt_next     = '0;
      cbc_next      = '0;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HDR0;
      hbi      <= 4'd0;
      len_code <= 7'd0;
      len      <= '0;
      len_big  <= 1'b0;
      masked   <= 1'b0;
      mask_key <= 32'd0;
      pcnt     <= '0;
      cbc      <= '0;
    end else if (advance) begin
      phase    <= phase_next;
      hbi      <= hbi_next;
      len_code <= len_code_next;
      len      <= len_next;
      len_big  <= len_big_next;
      masked   <= masked_next;
      mask_key <= mask_key_next;
      pcnt     <= pcnt_next;
      cbc      <= cbc_next;
    end
  end

endmodule

[design/wsdf_out_reg.sv]
// result register of the deframer: holds one result until taken downstream
// depends on wsdf_pkg
module wsdf_out_reg
  import wsdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               res_valid,
  input  res_t               res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         payload_byte,
  output logic [2:0]         status,
  output logic               result_last,
  output logic [COUNT_W-1:0] payload_count
);

  res_t held;

  // room for a new result when empty or being taken
  assign free = !out_valid || out_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      held <= res;
    end
  end

  assign payload_byte  = held.payload_byte;
  assign status        = held.status;
  assign result_last   = held.result_last;
  assign payload_count = held.payload_count;

endmodule

[design/websocket_frame_deframer_unmasker.sv]
// websocket receive deframer: header parse, length check, payload unmasking
// path: a byte waits in the input register, is parsed, and its result is held in the result register
// throughput: one byte per cycle while the result register is free, set by the single parse stage
// reset: rst (synchronous) empties both registers and returns to the first header byte
// depends on wsdf_pkg, wsdf_in_reg, wsdf_parser, wsdf_out_reg
module websocket_frame_deframer_unmasker
  import wsdf_pkg::*;
#(
  parameter int RECV_BUFFER_BYTES = RECV_BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               chunk_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         payload_byte,
  output logic [2:0]         status,
  output logic               result_last,
  output logic [COUNT_W-1:0] payload_count
);

  logic  item_valid;
  item_t item;
  logic  res_valid;
  res_t  res;
  logic  out_free;
  logic  advance;

  // a byte is parsed when the result register can take its result
  assign advance = item_valid && out_free;

  wsdf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .chunk_last (chunk_last),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wsdf_parser #(
    .RECV_BUFFER_BYTES (RECV_BUFFER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  wsdf_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .res_valid     (res_valid),
    .res           (res),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .status        (status),
    .result_last   (result_last),
    .payload_count (payload_count)
  );

`ifndef SYNTH
  // an empty input register always takes a byte
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> in_ready)
    else $error("input register empty but not ready");

  // every non-payload result ends its chunk
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_PAYLOAD)) |-> result_last)
    else $error("non-payload result without result_last");

  // the count is only reported on the final result
  a_count_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_last) |-> (payload_count == '0))
    else $error("payload_count nonzero on a non-final result");

  // no byte is parsed while the result register is held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !advance)
    else $error("parse advanced over a held result");
`endif

endmodule

[tb/sv/tb_websocket_frame_deframer_unmasker.sv]
`timescale 1ns / 1ps
// self-checking testbench for websocket_frame_deframer_unmasker: drives received chunks
// byte by byte and checks every result against a cycle-free model of the deframer
// depends on wsdf_pkg and websocket_frame_deframer_unmasker
module tb_websocket_frame_deframer_unmasker;
  import wsdf_pkg::*;

  localparam int         BUF_BYTES      = RECV_BUFFER_BYTES_DEF;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam int         RANDOM_ITEMS   = 750;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         MAX_GAP        = 8;
  localparam int         DRAIN_CYCLES   = 16;
  localparam int         IDLE_LIMIT     = 5000;
  localparam int         PRINT_LIMIT    = 40;

  typedef enum {LEN7, LEN16, LEN64} len_form_e;
  typedef enum {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_PERIODIC} sink_mode_e;

  logic               clk;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte    = 8'h00;
  logic               chunk_last = 1'b0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [7:0]         payload_byte;
  logic [2:0]         status;
  logic               result_last;
  logic [COUNT_W-1:0] payload_count;

  // deframer model state
  logic [2:0]         frame_phase;
  logic [3:0]         hdr_idx;
  logic [6:0]         len_code;
  logic [63:0]        decl_len;
  logic               masked;
  logic [31:0]        mask_key;
  logic [COUNT_W-1:0] pay_cnt;
  logic [COUNT_W-1:0] chunk_cnt;

  res_t       pending_deframe_results[$];
  logic [7:0] frame_bytes[$];
  int         mismatch_count = 0;
  int         bytes_sent     = 0;
  int         burst_left     = 0;
  bit         gaps_on        = 1'b1;
  bit         hold_request   = 1'b0;

  websocket_frame_deframer_unmasker #(
    .RECV_BUFFER_BYTES(BUF_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .chunk_last(chunk_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .payload_byte(payload_byte),
    .status(status),
    .result_last(result_last),
    .payload_count(payload_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- deframer model

  function automatic void clear_frame();
    frame_phase = PH_HDR0;
    hdr_idx     = '0;
    len_code    = '0;
    decl_len    = '0;
    masked      = 1'b0;
    mask_key    = '0;
    pay_cnt     = '0;
    chunk_cnt   = '0;
  endfunction

  function automatic void expect_result(logic [7:0] pb, logic [2:0] st, logic lst,
                                        logic [COUNT_W-1:0] cnt);
    res_t r;
    r.payload_byte  = pb;
    r.status        = st;
    r.result_last   = lst;
    r.payload_count = cnt;
    pending_deframe_results.push_back(r);
  endfunction

  function automatic void end_chunk(logic [2:0] st, logic [COUNT_W-1:0] cnt);
    expect_result(8'h00, st, 1'b1, cnt);
    clear_frame();
  endfunction

  // length check once the declared length is complete
  function automatic void length_resolved(logic last);
    int          hdr_len;
    logic [63:0] room;
    hdr_len = (len_code <= LEN_CODE_MAX7) ? HDR_LEN_SHORT :
              (len_code == LEN_CODE_EXT16) ? HDR_LEN_EXT16 : HDR_LEN_EXT64;
    room = 64'(BUF_BYTES - hdr_len);
    if (decl_len > room) begin
      expect_result(8'h00, ST_TOOLONG, 1'b1, '0);
      if (last) clear_frame();
      else frame_phase = PH_DROP;
    end else begin
      hdr_idx     = '0;
      frame_phase = masked ? PH_MASK : PH_PAYLOAD;
      if (last) end_chunk(masked ? ST_TRUNC : ST_NOPAYLOAD, '0);
    end
  endfunction

  // one accepted byte: advance the parse and queue the result it causes
  function automatic void deframe_byte(logic [7:0] b, logic last);
    logic [7:0] key_byte;
    logic [3:0] ext_need;
    // bytes past the receive buffer only matter when they end the chunk
    if (chunk_cnt >= BUF_BYTES) begin
      if (last) begin
        if (frame_phase == PH_PAYLOAD) end_chunk(ST_NOPAYLOAD, pay_cnt);
        else if (frame_phase >= PH_DROP) clear_frame();
        else end_chunk(ST_TRUNC, '0);
      end
      return;
    end
    chunk_cnt++;
    case (frame_phase)
      PH_HDR0: begin
        if (b[CLOSE_OPCODE_BIT]) begin
          expect_result(8'h00, ST_CLOSE, 1'b1, '0);
          if (last) clear_frame();
          else frame_phase = PH_DROP;
        end else begin
          frame_phase = PH_HDR1;
          if (last) end_chunk(ST_TRUNC, '0);
        end
      end
      PH_HDR1: begin
        masked   = b[MASK_FLAG_BIT];
        len_code = b[6:0];
        if (len_code <= LEN_CODE_MAX7) begin
          decl_len = 64'(len_code);
          length_resolved(last);
        end else begin
          decl_len    = '0;
          hdr_idx     = '0;
          frame_phase = PH_EXT;
          if (last) end_chunk(ST_TRUNC, '0);
        end
      end
      PH_EXT: begin
        ext_need = (len_code == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
        decl_len = {decl_len[55:0], b};
        hdr_idx++;
        if (hdr_idx >= ext_need) length_resolved(last);
        else if (last) end_chunk(ST_TRUNC, '0);
      end
      PH_MASK: begin
        mask_key = mask_key | (32'(b) << (8 * hdr_idx[1:0]));
        hdr_idx++;
        if (hdr_idx >= MASK_KEY_BYTES) begin
          hdr_idx     = '0;
          frame_phase = PH_PAYLOAD;
          if (last) end_chunk(ST_NOPAYLOAD, '0);
        end else if (last) begin
          end_chunk(ST_TRUNC, '0);
        end
      end
      PH_PAYLOAD: begin
        key_byte = masked ? mask_key[8 * pay_cnt[1:0] +: 8] : 8'h00;
        pay_cnt++;
        if (last) begin
          expect_result(b ^ key_byte, ST_PAYLOAD, 1'b1, pay_cnt);
          clear_frame();
        end else begin
          expect_result(b ^ key_byte, ST_PAYLOAD, 1'b0, '0);
        end
      end
      default: begin
        if (last) clear_frame();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- sender

  // one input transaction, with random gaps between bursts
  task automatic send_byte(input logic [7:0] b, input logic last);
    logic taken;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid   <= 1'b1;
    rx_byte    <= b;
    chunk_last <= last;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
    deframe_byte(b, last);
  endtask

  // sends the first cut bytes of the frame (all when cut is 0 or not below the frame size), last flag on the final one
  task automatic send_chunk(input int cut);
    int n;
    n = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_deframe_results.size() != 0);
  endtask

  function automatic void build_frame(logic [7:0] first, logic mask_bit, len_form_e form,
                                      logic [63:0] dlen, logic [31:0] key, int n_pay);
    frame_bytes.delete();
    frame_bytes.push_back(first);
    case (form)
      LEN7: frame_bytes.push_back({mask_bit, dlen[6:0]});
      LEN16: begin
        frame_bytes.push_back({mask_bit, LEN_CODE_EXT16});
        frame_bytes.push_back(dlen[15:8]);
        frame_bytes.push_back(dlen[7:0]);
      end
      default: begin
        frame_bytes.push_back({mask_bit, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(dlen[8 * i +: 8]);
      end
    endcase
    if (mask_bit)
      for (int i = 0; i < 4; i++) frame_bytes.push_back(key[8 * i +: 8]);
    for (int i = 0; i < n_pay; i++) frame_bytes.push_back(8'($urandom));
  endfunction

  // ---------------------------------------------------------------- tests

  // close opcode alone and with trailing bytes that must be dropped
  task automatic test_control_frames();
    frame_bytes = '{8'h88};
    send_chunk(0);
    frame_bytes = '{8'h09, 8'hFF};
    send_chunk(0);
  endtask

  // chunks ending inside the header or right at its end
  task automatic test_short_headers();
    frame_bytes = '{8'h81};
    send_chunk(0);
    frame_bytes = '{8'h02, 8'h00};
    send_chunk(0);
    frame_bytes = '{8'h82, 8'hFD};
    send_chunk(0);
    frame_bytes = '{8'h01, 8'h7E, 8'h00};
    send_chunk(0);
  endtask

  // 16-bit length one past the room left in the buffer, then a dropped byte
  task automatic test_length_limits();
    frame_bytes = '{8'h02, 8'h7E, 8'h0F, 8'hFD, 8'h55};
    send_chunk(0);
  endtask

  // masked payload that wraps around the key
  task automatic test_masked_payload();
    frame_bytes = '{8'h81, 8'h85, 8'hA5, 8'h3C, 8'h0F, 8'hF0,
                    8'h00, 8'hFF, 8'h5A, 8'hC3, 8'h81};
    send_chunk(0);
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    build_frame(8'h02, 1'b0, LEN7, 64'd40, 32'h0, 40);
    send_chunk(0);
    gaps_on = 1'b1;
  endtask

  // chunks longer than the receive buffer, and one that exactly fills it
  task automatic test_oversize_chunks();
    build_frame(8'h82, 1'b1, LEN16, 64'd100, $urandom, BUF_BYTES + 4 - 8);
    send_chunk(0);
    build_frame(8'h01, 1'b0, LEN7, 64'd125, 32'h0, BUF_BYTES - 2);
    send_chunk(0);
    frame_bytes.delete();
    frame_bytes.push_back(8'h88);
    repeat (BUF_BYTES + 1) frame_bytes.push_back(8'($urandom));
    send_chunk(0);
  endtask

  task automatic send_random_data_frame();
    logic [7:0]  first;
    logic        mask_bit;
    len_form_e   form;
    logic [63:0] dlen;
    int          room;
    int          sel;
    int          n_pay;
    first = 8'($urandom);
    first[CLOSE_OPCODE_BIT] = 1'b0;
    mask_bit = 1'($urandom);
    sel  = $urandom_range(0, 3);
    form = (sel < 2) ? LEN7 : (sel == 2) ? LEN16 : LEN64;
    room = BUF_BYTES - ((form == LEN7) ? HDR_LEN_SHORT :
                        (form == LEN16) ? HDR_LEN_EXT16 : HDR_LEN_EXT64);
    sel  = $urandom_range(0, 9);
    // lengths around the buffer limit, full-range values and small ones
    case (form)
      LEN7:  dlen = 64'($urandom_range(0, LEN_CODE_MAX7));
      LEN16: dlen = (sel < 2) ? 64'(room - 1 + $urandom_range(0, 2)) :
                    (sel < 4) ? 64'($urandom_range(0, 16'hFFFF)) :
                                64'($urandom_range(0, 300));
      default: dlen = (sel < 2) ? 64'(room - 1 + $urandom_range(0, 2)) :
                      (sel < 4) ? {$urandom, $urandom} :
                      (sel < 5) ? (64'd1 << $urandom_range(12, 63)) :
                                  64'($urandom_range(0, 300));
    endcase
    n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
    build_frame(first, mask_bit, form, dlen, $urandom, n_pay);
    send_chunk(($urandom_range(0, 6) == 0) ? $urandom_range(1, frame_bytes.size()) : 0);
  endtask

  // mostly well-formed frames, some control frames and raw noise
  task automatic test_random_frames();
    int target;
    int pick;
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 65) begin
        send_random_data_frame();
      end else if (pick < 80) begin
        frame_bytes.delete();
        frame_bytes.push_back(8'($urandom) | (8'h01 << CLOSE_OPCODE_BIT));
        repeat ($urandom_range(0, 5)) frame_bytes.push_back(8'($urandom));
        send_chunk(0);
      end else begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
        send_chunk(0);
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- receiver

  // out_ready pattern, changed every so often, plus a long hold on request
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         hold_left;
    int         cyc;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    cyc       = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_COIN:   out_ready <= 1'($urandom);
          SINK_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:     out_ready <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  // compare each result transaction with the oldest expectation
  initial begin : result_check
    res_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        if (pending_deframe_results.size() == 0) begin
          report_mismatch("result with nothing expected, status", status, 0);
        end else begin
          want = pending_deframe_results.pop_front();
          if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", payload_byte, want.payload_byte);
          if (status !== want.status)
            report_mismatch("status", status, want.status);
          if (result_last !== want.result_last)
            report_mismatch("result_last", result_last, want.result_last);
          if (payload_count !== want.payload_count)
            report_mismatch("payload_count", payload_count, want.payload_count);
        end
      end
    end
  end

  // ends the run when no transaction happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && in_ready) || (out_valid === 1'b1 && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("websocket_frame_deframer_unmasker: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_frame();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_control_frames();
    wait_drained();
    test_short_headers();
    wait_drained();
    test_length_limits();
    wait_drained();
    test_masked_payload();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_oversize_chunks();
    wait_drained();
    test_random_frames();
    wait_drained();

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_deframe_results.size() != 0)
      report_mismatch("results still expected", 0, pending_deframe_results.size());

    if (mismatch_count == 0)
      $display("websocket_frame_deframer_unmasker: match");
    else
      $display("websocket_frame_deframer_unmasker: mismatch");
    $finish;
  end

endmodule

[filelist.f]
design/wsdf_pkg.sv
design/wsdf_in_reg.sv
design/wsdf_parser.sv
design/wsdf_out_reg.sv
design/websocket_frame_deframer_unmasker.sv
tb/sv/tb_websocket_frame_deframer_unmasker.sv
